>>> hdl/pmb_pkg.sv
// Package: shared constants, item kinds and controller states of the byte matcher.
`default_nettype none
package pmb_pkg;

  // defaults of the top-level parameters
  localparam int PatternsDef = 8;
  localparam int MaxLenDef = 64;
  localparam int TrackerEntriesDef = 256;

  // events reported per access, beyond that matches only update state
  localparam int MaxEvents = 64;
  // pc hash folds the upper word onto the lower word
  localparam int HashShift = 32;

  // field widths of the ports
  localparam int KindW = 2;
  localparam int XlenW = 64;
  localparam int IdW = 3;
  localparam int CharPosW = 6;
  localparam int LenInW = 7;
  localparam int HitW = 16;
  localparam int CfgW = 4;

  typedef enum logic [KindW-1:0] {
    KIND_ACCESS  = 2'd0,
    KIND_LOAD    = 2'd1,
    KIND_SET_LEN = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOOK,
    ST_SCAN,
    ST_EMIT,
    ST_FLUSH,
    ST_WB
  } state_t;

endpackage
`default_nettype wire

>>> hdl/pmb_pattern_store.sv
// Pattern byte memories (one per pattern) and the pattern length registers.
`default_nettype none
module pmb_pattern_store #(
  parameter int PATTERNS = 8,
  parameter int MAX_LEN = 64,
  parameter int AW = $clog2(MAX_LEN),
  parameter int PSW = $clog2(MAX_LEN + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          ld_en,
  input  wire logic [pmb_pkg::IdW-1:0]       ld_idx,
  input  wire logic [pmb_pkg::CharPosW-1:0]  ld_pos,
  input  wire logic [7:0]                    ld_val,
  input  wire logic                          len_en,
  input  wire logic [pmb_pkg::IdW-1:0]       len_idx,
  input  wire logic [pmb_pkg::LenInW-1:0]    len_val,
  input  wire logic                          len_clr,
  input  wire logic [PATTERNS-1:0][AW-1:0]   rd_addr,
  output logic      [PATTERNS-1:0][7:0]      rd_data,
  output logic      [PATTERNS-1:0][PSW-1:0]  lens
);
  import pmb_pkg::*;

  logic                 ld_ok;
  logic                 len_ok;
  logic [PSW-1:0]       len_clip;
  logic [PATTERNS-1:0][PSW-1:0] lens_r;

  // bad slots and positions are dropped
  assign ld_ok  = ld_en && (int'(ld_idx) < PATTERNS) && (int'(ld_pos) < MAX_LEN);
  assign len_ok = len_en && (int'(len_idx) < PATTERNS);
  assign len_clip = (int'(len_val) > MAX_LEN) ? PSW'(MAX_LEN) : PSW'(len_val);
  assign lens = lens_r;

  // one byte memory per pattern so every pattern is read each cycle
  for (genvar p = 0; p < PATTERNS; p++) begin : g_pat
    logic [7:0] mem [MAX_LEN];
    logic [7:0] q_r;

    always_ff @(posedge clk) begin
      if (ld_ok && (int'(ld_idx) == p)) begin
        mem[AW'(ld_pos)] <= ld_val;
      end
      q_r <= mem[rd_addr[p]];
    end
    assign rd_data[p] = q_r;

    // length register, cleared by reset or by an empty pattern set
    always_ff @(posedge clk) begin
      if (!rst_n || len_clr) begin
        lens_r[p] <= '0;
      end else if (len_ok && (int'(len_idx) == p)) begin
        lens_r[p] <= len_clip;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/pmb_tracker.sv
// Per-pc tracker: tag, position row and hit-count row memories for both streams.
`default_nettype none
module pmb_tracker #(
  parameter int PATTERNS = 8,
  parameter int TRACKER_ENTRIES = 256,
  parameter int PSW = 7,
  parameter int SW = $clog2(TRACKER_ENTRIES)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [pmb_pkg::XlenW-1:0]            pc,
  input  wire logic                                 store_sel,
  input  wire logic                                 rd_en,
  input  wire logic                                 wr_en,
  input  wire logic [PATTERNS-1:0][PSW-1:0]         wr_pos,
  input  wire logic [PATTERNS-1:0][pmb_pkg::HitW-1:0] wr_hc,
  output logic      [PATTERNS-1:0][PSW-1:0]         rd_pos,
  output logic      [PATTERNS-1:0][pmb_pkg::HitW-1:0] rd_hc
);
  import pmb_pkg::*;

  logic [SW-1:0]          slot;
  logic [XlenW/2-1:0]     fold;
  logic [XlenW-1:0]       rtag [TRACKER_ENTRIES];
  logic [XlenW-1:0]       wtag [TRACKER_ENTRIES];
  logic [PATTERNS-1:0][PSW-1:0] rpos [TRACKER_ENTRIES];
  logic [PATTERNS-1:0][PSW-1:0] wpos [TRACKER_ENTRIES];
  logic [PATTERNS-1:0][HitW-1:0] hcm [TRACKER_ENTRIES];
  logic [TRACKER_ENTRIES-1:0] rvld_r;
  logic [TRACKER_ENTRIES-1:0] wvld_r;
  logic [TRACKER_ENTRIES-1:0] hvld_r;
  logic [XlenW-1:0]       tag_q_r;
  logic                   vld_q_r;
  logic                   hvld_q_r;
  logic [PATTERNS-1:0][PSW-1:0]  pos_q_r;
  logic [PATTERNS-1:0][HitW-1:0] hc_q_r;

  // slot hash: low word xor high word, low bits (entry count is a power of two)
  assign fold = pc[XlenW/2-1:0] ^ pc[XlenW-1:HashShift];
  assign slot = fold[SW-1:0];

  // tag and position memories, one set per stream
  always_ff @(posedge clk) begin
    if (wr_en && store_sel) begin
      wtag[slot] <= pc;
      wpos[slot] <= wr_pos;
    end
    if (wr_en && !store_sel) begin
      rtag[slot] <= pc;
      rpos[slot] <= wr_pos;
    end
    if (rd_en) begin
      tag_q_r <= store_sel ? wtag[slot] : rtag[slot];
      pos_q_r <= store_sel ? wpos[slot] : rpos[slot];
    end
  end

  // shared hit-count rows
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hcm[slot] <= wr_hc;
    end
    if (rd_en) begin
      hc_q_r <= hcm[slot];
    end
  end

  // valid bits per row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r   <= '0;
      wvld_r   <= '0;
      hvld_r   <= '0;
      vld_q_r  <= 1'b0;
      hvld_q_r <= 1'b0;
    end else begin
      if (wr_en) begin
        hvld_r[slot] <= 1'b1;
        if (store_sel) begin
          wvld_r[slot] <= 1'b1;
        end else begin
          rvld_r[slot] <= 1'b1;
        end
      end
      if (rd_en) begin
        vld_q_r  <= store_sel ? wvld_r[slot] : rvld_r[slot];
        hvld_q_r <= hvld_r[slot];
      end
    end
  end

  // a tag miss or an unused row reads as all-zero positions
  assign rd_pos = (vld_q_r && (tag_q_r == pc)) ? pos_q_r : '0;
  assign rd_hc  = hvld_q_r ? hc_q_r : '0;

endmodule
`default_nettype wire

>>> hdl/per_pc_multi_pattern_byte_matcher.sv
// Top level: command port, byte scan controller and match event output.
//
// A memory access keeps busy high after its accept edge through these states in order:
// a tracker read, a lookup state, a scan state per data byte (all patterns compared at once,
// each pattern memory read once a cycle), an emit state per completed match, a flush state
// that hands out the last event, and a write-back of the tracker row; the next beat is
// taken in the idle cycle that follows. Pattern-load and length items complete at the
// accept edge and keep busy low. Events leave one per cycle on out_valid while emit states
// follow each other, wait as the pending event until the next emit or the flush state, and
// cannot be held off; the last event of an access carries out_last. The tracker slot is a
// fold of the pc, so TRACKER_ENTRIES must be a power of two.
`default_nettype none
module per_pc_multi_pattern_byte_matcher #(
  parameter int PATTERNS = pmb_pkg::PatternsDef,
  parameter int MAX_LEN = pmb_pkg::MaxLenDef,
  parameter int TRACKER_ENTRIES = pmb_pkg::TrackerEntriesDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pmb_pkg::KindW-1:0]     in_kind,
  input  wire logic [pmb_pkg::XlenW-1:0]     in_pc,
  input  wire logic [pmb_pkg::XlenW-1:0]     in_addr,
  input  wire logic [1:0]                    in_size_log2,
  input  wire logic                          in_store,
  input  wire logic [pmb_pkg::XlenW-1:0]     in_data,
  input  wire logic [pmb_pkg::IdW-1:0]       in_pattern_index,
  input  wire logic [pmb_pkg::CharPosW-1:0]  in_char_pos,
  input  wire logic [7:0]                    in_char_value,
  input  wire logic [pmb_pkg::LenInW-1:0]    in_pattern_length,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pmb_pkg::CfgW-1:0]      cfg_data,
  output logic                               out_valid,
  output logic      [pmb_pkg::IdW-1:0]       out_pattern_id,
  output logic      [pmb_pkg::XlenW-1:0]     out_match_pc,
  output logic      [pmb_pkg::XlenW-1:0]     out_start_addr,
  output logic                               out_match_store,
  output logic      [pmb_pkg::HitW-1:0]      out_hit_count,
  output logic                               out_last
);
  import pmb_pkg::*;

  localparam int AW  = $clog2(MAX_LEN);
  localparam int PSW = $clog2(MAX_LEN + 1);
  localparam int PIW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int NW  = $clog2(MaxEvents + 1);

  state_t state_r, state_nxt;

  logic                  acc;
  logic [CfgW-1:0]       piu_r;
  int                    active;
  logic                  cfg_we;

  // latched access
  logic [XlenW-1:0]      pc_r, addr_r, data_r;
  logic [1:0]            size_r;
  logic                  wr_r;
  logic [2:0]            i_r;
  logic                  last_byte;
  logic [7:0]            cur_byte;

  // scan state
  logic [PATTERNS-1:0][PSW-1:0]  pos_r, pos_nxt;
  logic [PATTERNS-1:0][HitW-1:0] hc_r, hc_scan;
  logic [PATTERNS-1:0]           done;
  logic [PATTERNS-1:0]           mask_r;
  logic [PATTERNS-1:0][AW-1:0]   pat_addr;
  logic [PATTERNS-1:0][7:0]      pat_q;
  logic [PATTERNS-1:0][PSW-1:0]  lens;
  logic [PATTERNS-1:0][PSW-1:0]  trk_pos;
  logic [PATTERNS-1:0][HitW-1:0] trk_hc;

  // event selection and the pending event
  logic [PIW-1:0]        sel;
  logic [XlenW-1:0]      sel_addr;
  logic [NW-1:0]         n_r;
  logic                  pend_v_r;
  logic [PIW-1:0]        pend_id_r;
  logic [XlenW-1:0]      pend_addr_r;
  logic [HitW-1:0]       pend_hc_r;

  // controller outputs
  logic                  trk_rd, trk_wr;

  assign acc       = start && !busy;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign active    = (int'(piu_r) > PATTERNS) ? PATTERNS : int'(piu_r);

  pmb_pattern_store #(.PATTERNS(PATTERNS), .MAX_LEN(MAX_LEN), .AW(AW), .PSW(PSW)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_en   (acc && (in_kind == KIND_LOAD)),
    .ld_idx  (in_pattern_index),
    .ld_pos  (in_char_pos),
    .ld_val  (in_char_value),
    .len_en  (acc && (in_kind == KIND_SET_LEN)),
    .len_idx (in_pattern_index),
    .len_val (in_pattern_length),
    .len_clr (cfg_we && (cfg_data == '0)),
    .rd_addr (pat_addr),
    .rd_data (pat_q),
    .lens    (lens)
  );

  pmb_tracker #(.PATTERNS(PATTERNS), .TRACKER_ENTRIES(TRACKER_ENTRIES), .PSW(PSW)) u_trk (
    .clk       (clk),
    .rst_n     (rst_n),
    .pc        (pc_r),
    .store_sel (wr_r),
    .rd_en     (trk_rd),
    .wr_en     (trk_wr),
    .wr_pos    (pos_r),
    .wr_hc     (hc_r),
    .rd_pos    (trk_pos),
    .rd_hc     (trk_hc)
  );

  // current byte and end of access
  assign cur_byte  = data_r[8*i_r +: 8];
  assign last_byte = (i_r == 3'((4'd1 << size_r) - 4'd1));

  // one byte against every active pattern; the lookup state loads the tracker positions
  always_comb begin
    pos_nxt = pos_r;
    hc_scan = hc_r;
    done    = '0;
    if (state_r == ST_LOOK) begin
      pos_nxt = trk_pos;
    end else if (state_r == ST_SCAN) begin
      for (int p = 0; p < PATTERNS; p++) begin
        if (p < active) begin
          if ((lens[p] == '0) || (pos_r[p] >= lens[p])) begin
            pos_nxt[p] = '0;
          end else if (pat_q[p] == cur_byte) begin
            if (pos_r[p] + PSW'(1) == lens[p]) begin
              pos_nxt[p] = '0;
              done[p]    = 1'b1;
              if (hc_r[p] != '1) begin
                hc_scan[p] = hc_r[p] + HitW'(1);
              end
            end else begin
              pos_nxt[p] = pos_r[p] + PSW'(1);
            end
          end else begin
            pos_nxt[p] = '0;
          end
        end
      end
    end
  end

  // pattern byte at the next position, ready next cycle
  always_comb begin
    for (int p = 0; p < PATTERNS; p++) begin
      pat_addr[p] = pos_nxt[p][AW-1:0];
    end
  end

  // lowest pending pattern of the event mask
  always_comb begin
    sel = '0;
    for (int p = PATTERNS - 1; p >= 0; p--) begin
      if (mask_r[p]) begin
        sel = PIW'(p);
      end
    end
    sel_addr = addr_r + XlenW'(i_r) - XlenW'(lens[sel]) + XlenW'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (acc && (in_kind == KIND_ACCESS)) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_LOOK;
      ST_LOOK:  state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (done != '0) begin
          state_nxt = ST_EMIT;
        end else if (last_byte) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_EMIT: begin
        if ((mask_r & (mask_r - PATTERNS'(1))) == '0) begin
          state_nxt = last_byte ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_FLUSH: state_nxt = ST_WB;
      ST_WB:    state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    trk_rd = 1'b0;
    trk_wr = 1'b0;
    busy   = 1'b1;
    case (state_r)
      ST_IDLE: busy   = 1'b0;
      ST_READ: trk_rd = 1'b1;
      ST_WB:   trk_wr = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      piu_r     <= '0;
      pend_v_r  <= 1'b0;
      out_valid <= 1'b0;
      n_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_we) begin
        piu_r <= cfg_data;
      end
      if (state_r == ST_READ) begin
        n_r <= '0;
      end
      if ((state_r == ST_EMIT) && (n_r < NW'(MaxEvents))) begin
        n_r       <= n_r + NW'(1);
        pend_v_r  <= 1'b1;
        out_valid <= pend_v_r;
      end
      if (state_r == ST_FLUSH) begin
        out_valid <= pend_v_r;
        pend_v_r  <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (acc) begin
      pc_r   <= in_pc;
      addr_r <= in_addr;
      data_r <= in_data;
      size_r <= in_size_log2;
      wr_r   <= in_store;
    end
    pos_r <= pos_nxt;
    case (state_r)
      ST_LOOK: begin
        hc_r <= trk_hc;
        i_r  <= '0;
      end
      ST_SCAN: begin
        hc_r   <= hc_scan;
        mask_r <= done;
        if ((done == '0) && !last_byte) begin
          i_r <= i_r + 3'd1;
        end
      end
      ST_EMIT: begin
        mask_r[sel] <= 1'b0;
        if ((mask_r & (mask_r - PATTERNS'(1))) == '0 && !last_byte) begin
          i_r <= i_r + 3'd1;
        end
        if (n_r < NW'(MaxEvents)) begin
          pend_id_r   <= sel;
          pend_addr_r <= sel_addr;
          pend_hc_r   <= hc_r[sel];
        end
      end
      default: ;
    endcase
    // output register takes the pending event when it leaves
    if (((state_r == ST_EMIT) && (n_r < NW'(MaxEvents))) || (state_r == ST_FLUSH)) begin
      out_pattern_id  <= IdW'(pend_id_r);
      out_match_pc    <= pc_r;
      out_start_addr  <= pend_addr_r;
      out_match_store <= wr_r;
      out_hit_count   <= pend_hc_r;
      out_last        <= (state_r == ST_FLUSH);
    end
  end

  // an event is only ever shown while an access is in progress
  a_out_in_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r != ST_IDLE))
    else $error("event outside an access");

  // nothing follows the final event of an access
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("event after last");

  // the emit state always has a completed pattern to report
  a_emit_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (mask_r != '0))
    else $error("emit with empty mask");

  // event count stays within the report limit
  a_event_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(MaxEvents))
    else $error("event count overflow");

endmodule
`default_nettype wire
